// File: rtl/core/dtd_pkg.sv
// ----------------------------------------------------------------------------
// Date-time difference package
// Field widths, calendar constants, reciprocal constants and the month table
// shared by the stamp converter and the top level.
// ----------------------------------------------------------------------------
package dtd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int HOURS_W  = 27;

    // day count since 0001-01-01 and seconds within a (possibly overlong) day
    localparam int DAYS_W   = 23;
    localparam int TOD_W    = 17;
    localparam int MIDX_W   = 4;
    localparam int MDAYS_W  = 9;
    localparam int CENT_W   = 8;
    localparam int REM_W    = 12;

    localparam int DAYS_PER_YEAR  = 365;
    localparam int YEARS_PER_CENT = 100;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int MONTHS         = 12;

    // x / d = (x * RECIP) >> SHIFT, exact over the stated input range
    localparam int RECIP_100       = 5243;
    localparam int RECIP_100_SH    = 19;
    localparam int RECIP_3600      = 74566;
    localparam int RECIP_3600_SH   = 28;
    localparam int RECIP_60        = 4370;
    localparam int RECIP_60_SH     = 18;

    // stamp converter is two stages, difference datapath eight more
    localparam int PIPE_DEPTH = 10;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_stamp;

    // days in the whole months before month index mi (0 = January)
    function automatic logic [MDAYS_W-1:0] days_before(input logic [MIDX_W-1:0] mi);
        logic [MDAYS_W-1:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/dtd_stamp.sv
// ----------------------------------------------------------------------------
// Date-time to day count converter
// Two register stages: constant divisions by 100, then the closed-form day
// count with the leap-day correction. Time of day is passed as seconds.
// ----------------------------------------------------------------------------
module dtd_stamp (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  dtd_pkg::t_stamp               i_stamp,
    output logic [dtd_pkg::DAYS_W-1:0]    o_days,
    output logic [dtd_pkg::TOD_W-1:0]     o_tod
);
    import dtd_pkg::*;

    localparam int PQ_W = YEAR_W + 13;

    logic [YEAR_W-1:0]  w_past;
    logic [PQ_W-1:0]    w_pq_prod;
    logic [PQ_W-1:0]    w_yq_prod;
    logic [MIDX_W-1:0]  w_mi;
    logic [TOD_W-1:0]   w_tod;

    logic [YEAR_W-1:0]  r_year;
    logic [YEAR_W-1:0]  r_past;
    logic [CENT_W-1:0]  r_pq;
    logic [CENT_W-1:0]  r_yq;
    logic [MIDX_W-1:0]  r_mi;
    logic [DAY_W-1:0]   r_day;
    logic [TOD_W-1:0]   r_tod;

    logic               w_century;
    logic               w_leap;
    logic               w_leap_add;
    logic [DAYS_W-1:0]  w_days;

    // stage 1
    always_comb begin
        w_past    = (i_stamp.year == '0) ? '0 : i_stamp.year - YEAR_W'(1);
        w_pq_prod = PQ_W'(w_past) * PQ_W'(RECIP_100);
        w_yq_prod = PQ_W'(i_stamp.year) * PQ_W'(RECIP_100);
        if (i_stamp.month == '0) begin
            w_mi = '0;
        end else if (i_stamp.month > MIDX_W'(MONTHS)) begin
            w_mi = MIDX_W'(MONTHS);
        end else begin
            w_mi = i_stamp.month - MIDX_W'(1);
        end
        w_tod = TOD_W'(i_stamp.hour) * TOD_W'(SECS_PER_HOUR)
              + TOD_W'(i_stamp.minute) * TOD_W'(SECS_PER_MIN)
              + TOD_W'(i_stamp.second);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_year <= i_stamp.year;
            r_past <= w_past;
            r_pq   <= w_pq_prod[RECIP_100_SH +: CENT_W];
            r_yq   <= w_yq_prod[RECIP_100_SH +: CENT_W];
            r_mi   <= w_mi;
            r_day  <= i_stamp.day;
            r_tod  <= w_tod;
        end
    end

    // stage 2: year 0 counts as leap since 0 is a multiple of 400
    always_comb begin
        w_century  = (r_year == YEAR_W'(r_yq) * YEAR_W'(YEARS_PER_CENT));
        w_leap     = (w_century) ? (r_yq[1:0] == 2'b00) : (r_year[1:0] == 2'b00);
        w_leap_add = w_leap && (r_mi >= MIDX_W'(2));
        w_days     = DAYS_W'(r_past) * DAYS_W'(DAYS_PER_YEAR)
                   + DAYS_W'(r_past >> 2)
                   - DAYS_W'(r_pq)
                   + DAYS_W'(r_pq >> 2)
                   + DAYS_W'(days_before(r_mi))
                   + DAYS_W'(w_leap_add)
                   + DAYS_W'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_days <= w_days;
            o_tod  <= r_tod;
        end
    end

endmodule

// File: rtl/core/datetime_difference_hms.sv
// ----------------------------------------------------------------------------
// Date-time difference in hours, minutes and seconds
// Absolute difference of two proleptic Gregorian date-times, split into
// whole hours and remaining minutes and seconds.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_year_a .. i_second_b
//  result    out        o_valid / i_stall    o_diff_hours, o_diff_minutes,
//                                            o_diff_seconds
//
//  One request per cycle while o_stall is low; the datapath has ten stages:
//  two stages of day counting, then difference, sign, magnitude, day
//  normalise and four split stages.
//  Synchronous active-low reset clears the stage valid bits only.
//  A held result with i_stall high freezes every stage; o_stall follows.
// ----------------------------------------------------------------------------
module datetime_difference_hms (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dtd_pkg::YEAR_W-1:0]    i_year_a,
    input  logic [dtd_pkg::MONTH_W-1:0]   i_month_a,
    input  logic [dtd_pkg::DAY_W-1:0]     i_day_a,
    input  logic [dtd_pkg::HOUR_W-1:0]    i_hour_a,
    input  logic [dtd_pkg::MIN_W-1:0]     i_minute_a,
    input  logic [dtd_pkg::SEC_W-1:0]     i_second_a,
    input  logic [dtd_pkg::YEAR_W-1:0]    i_year_b,
    input  logic [dtd_pkg::MONTH_W-1:0]   i_month_b,
    input  logic [dtd_pkg::DAY_W-1:0]     i_day_b,
    input  logic [dtd_pkg::HOUR_W-1:0]    i_hour_b,
    input  logic [dtd_pkg::MIN_W-1:0]     i_minute_b,
    input  logic [dtd_pkg::SEC_W-1:0]     i_second_b,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtd_pkg::HOURS_W-1:0]   o_diff_hours,
    output logic [dtd_pkg::MIN_W-1:0]     o_diff_minutes,
    output logic [dtd_pkg::SEC_W-1:0]     o_diff_seconds
);
    import dtd_pkg::*;

    localparam int DD_W   = DAYS_W + 1;
    localparam int DT_W   = TOD_W + 1;
    localparam int TOT_W  = 42;
    localparam int DA_W   = DAYS_W + 2;
    localparam int TN_W   = TOD_W + 2;
    localparam int QP_W   = 2 * TOD_W;
    localparam int Q_W    = 5;
    localparam int MP_W   = REM_W + 13;

    localparam logic signed [TOT_W-1:0] SPD_S    = TOT_W'(SECS_PER_DAY);
    localparam logic signed [TN_W-1:0]  DAY_S    = TN_W'(SECS_PER_DAY);
    localparam logic signed [TN_W-1:0]  TWO_DAYS = TN_W'(2 * SECS_PER_DAY);

    logic                   w_en;
    logic [PIPE_DEPTH-1:0]  r_v;
    logic [PIPE_DEPTH-1:0]  n_v;

    t_stamp                 w_stamp_a;
    t_stamp                 w_stamp_b;
    logic [DAYS_W-1:0]      w_days_a;
    logic [DAYS_W-1:0]      w_days_b;
    logic [TOD_W-1:0]       w_tod_a;
    logic [TOD_W-1:0]       w_tod_b;

    logic signed [DD_W-1:0]  r_dd;
    logic signed [DT_W-1:0]  r_dt;
    logic signed [TOT_W-1:0] w_tot;
    logic                    r_neg;
    logic signed [DD_W-1:0]  r_dd4;
    logic signed [DT_W-1:0]  r_dt4;
    logic signed [DA_W-1:0]  w_dabs;
    logic signed [DT_W-1:0]  w_tabs;
    logic signed [DA_W-1:0]  r_dabs;
    logic signed [DT_W-1:0]  r_tabs;
    logic signed [TN_W-1:0]  w_t19;
    logic signed [TN_W-1:0]  w_tn;
    logic signed [DA_W-1:0]  w_dn;
    logic [DAYS_W-1:0]       r_dn;
    logic [TOD_W-1:0]        r_tn;
    logic [QP_W-1:0]         w_qprod;
    logic [Q_W-1:0]          r_q;
    logic [DAYS_W-1:0]       r_dn7;
    logic [TOD_W-1:0]        r_tn7;
    logic [HOURS_W-1:0]      r_hours;
    logic [REM_W-1:0]        r_rem;
    logic [MP_W-1:0]         w_mprod;
    logic [HOURS_W-1:0]      r_hours9;
    logic [MIN_W-1:0]        r_min;
    logic [REM_W-1:0]        r_rem9;
    logic [HOURS_W-1:0]      r_out_hours;
    logic [MIN_W-1:0]        r_out_min;
    logic [SEC_W-1:0]        r_out_sec;

    // hold every stage while the last one holds an untaken result
    assign w_en    = !(r_v[PIPE_DEPTH-1] && i_stall);
    assign o_stall = r_v[PIPE_DEPTH-1] && i_stall;
    assign o_valid = r_v[PIPE_DEPTH-1];
    assign n_v     = {r_v[PIPE_DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= n_v;
        end
    end

    assign w_stamp_a = '{year: i_year_a, month: i_month_a, day: i_day_a,
                         hour: i_hour_a, minute: i_minute_a, second: i_second_a};
    assign w_stamp_b = '{year: i_year_b, month: i_month_b, day: i_day_b,
                         hour: i_hour_b, minute: i_minute_b, second: i_second_b};

    dtd_stamp u_stamp_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_stamp (w_stamp_a),
        .o_days  (w_days_a),
        .o_tod   (w_tod_a)
    );

    dtd_stamp u_stamp_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_stamp (w_stamp_b),
        .o_days  (w_days_b),
        .o_tod   (w_tod_b)
    );

    // stage 4 sign of the full second count; stage 5 magnitude
    always_comb begin
        w_tot  = TOT_W'(r_dd) * SPD_S + TOT_W'(r_dt);
        w_dabs = r_neg ? -DA_W'(r_dd4) : DA_W'(r_dd4);
        w_tabs = r_neg ? -r_dt4 : r_dt4;
    end

    // stage 6: move whole days out of or into the time of day
    always_comb begin
        w_t19 = TN_W'(r_tabs);
        if (w_t19 < -DAY_S) begin
            w_tn = w_t19 + TWO_DAYS;
            w_dn = r_dabs - DA_W'(2);
        end else if (w_t19 < TN_W'(0)) begin
            w_tn = w_t19 + DAY_S;
            w_dn = r_dabs - DA_W'(1);
        end else if (w_t19 >= DAY_S) begin
            w_tn = w_t19 - DAY_S;
            w_dn = r_dabs + DA_W'(1);
        end else begin
            w_tn = w_t19;
            w_dn = r_dabs;
        end
    end

    assign w_qprod = QP_W'(r_tn) * QP_W'(RECIP_3600);
    assign w_mprod = MP_W'(r_rem) * MP_W'(RECIP_60);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dd        <= $signed({1'b0, w_days_b} - {1'b0, w_days_a});
            r_dt        <= $signed({1'b0, w_tod_b} - {1'b0, w_tod_a});
            r_neg       <= w_tot[TOT_W-1];
            r_dd4       <= r_dd;
            r_dt4       <= r_dt;
            r_dabs      <= w_dabs;
            r_tabs      <= w_tabs;
            r_dn        <= w_dn[DAYS_W-1:0];
            r_tn        <= w_tn[TOD_W-1:0];
            r_q         <= w_qprod[RECIP_3600_SH +: Q_W];
            r_dn7       <= r_dn;
            r_tn7       <= r_tn;
            r_hours     <= HOURS_W'(r_dn7) * HOURS_W'(HOURS_PER_DAY) + HOURS_W'(r_q);
            r_rem       <= REM_W'(r_tn7 - TOD_W'(r_q) * TOD_W'(SECS_PER_HOUR));
            r_hours9    <= r_hours;
            r_min       <= w_mprod[RECIP_60_SH +: MIN_W];
            r_rem9      <= r_rem;
            r_out_hours <= r_hours9;
            r_out_min   <= r_min;
            r_out_sec   <= SEC_W'(r_rem9 - REM_W'(r_min) * REM_W'(SECS_PER_MIN));
        end
    end

    assign o_diff_hours   = r_out_hours;
    assign o_diff_minutes = r_out_min;
    assign o_diff_seconds = r_out_sec;

`ifndef ASSERT_OFF
    a_norm_tod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> (r_tn < TOD_W'(SECS_PER_DAY)))
        else $error("normalised time of day out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[7] |-> (r_rem < REM_W'(SECS_PER_HOUR)))
        else $error("remainder within the hour out of range");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_diff_minutes < MIN_W'(SECS_PER_MIN)
                     && o_diff_seconds < SEC_W'(SECS_PER_MIN)))
        else $error("minutes or seconds of result out of range");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_v))
        else $error("stage valid bits moved while stalled");
`endif

endmodule
